// ----- sv/fft_pkg.sv -----
// Package for the flow field tracer: sizes, register codes, state type.
package fft_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int FracBits  = 8;
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int RowBits   = $clog2(MaxHeight);
    localparam int AddrBits  = ColBits + RowBits;
    localparam int StepFrac  = 8;

    localparam logic [2:0] REG_NUM_STEPS = 3'd0;
    localparam logic [2:0] REG_STEP_SIZE = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_ACC,
        ST_SUM,
        ST_MOVE,
        ST_OUT
    } t_state;

    // store port request from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic [AddrBits-1:0] rd_addr;
        logic                wr_en;
        logic [AddrBits-1:0] wr_addr;
        logic [15:0]         wr_x;
        logic [15:0]         wr_y;
    } t_mem_req;
endpackage

// ----- sv/fft_flow_mem.sv -----
// Flow field store: both components in one word, one write and one read port.
module fft_flow_mem (
    input  logic                        i_clk,
    input  fft_pkg::t_mem_req           i_req,
    output logic [15:0]                 o_rd_x,
    output logic [15:0]                 o_rd_y
);
    logic [31:0] r_mem [fft_pkg::MaxWidth*fft_pkg::MaxHeight];
    logic [31:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {i_req.wr_x, i_req.wr_y};
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_x = r_rd[31:16];
    assign o_rd_y = r_rd[15:0];
endmodule

// ----- sv/flow_field_tracer.sv -----
// Flow field tracer top level: config, load/trace sequencer, output register.
//  channel  direction  handshake      payload
//  cfg      in         valid/ready    index, data
//  in       in         valid/stall    req_type, entry_*, start_*
//  out      out        valid/stall    end_x, end_y
// A load is written to the store when it is accepted. A trace result is valid
// after up to num_steps steps, each of four reads (address, read and accumulate
// states) on the single store read port, then move and step check; a trace
// that converges skips its last step check. Reset sets registers to defaults;
// store contents are undefined until loaded. Input is stalled while a trace
// runs or a result waits; no clearing pass.
module flow_field_tracer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_entry_col,
    input  logic [7:0]  i_entry_row,
    input  logic signed [15:0] i_entry_flow_x,
    input  logic signed [15:0] i_entry_flow_y,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_end_x,
    output logic [15:0] o_end_y
);
    localparam int CB = fft_pkg::ColBits;
    localparam int RB = fft_pkg::RowBits;
    localparam int FB = fft_pkg::FracBits;

    logic [9:0]  r_num_steps;
    logic [11:0] r_step_size;
    logic [8:0]  r_width, r_height;
    logic [7:0]  r_thr;

    fft_pkg::t_state r_state, n_state;
    logic [15:0] r_px, r_py;
    logic [9:0]  r_cnt;
    logic [1:0]  r_k;
    logic [17:0] r_wt;
    logic signed [35:0] r_sx, r_sy;
    logic signed [19:0] r_fx, r_fy;
    logic [15:0] r_ox, r_oy;
    logic        r_ovalid;
    logic [8:0]  r_wu, r_hu;
    fft_pkg::t_mem_req w_req;
    logic [15:0] w_rd_x, w_rd_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_steps <= 10'd200;
            r_step_size <= 12'd256;
            r_width     <= 9'd256;
            r_height    <= 9'd256;
            r_thr       <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fft_pkg::REG_NUM_STEPS: r_num_steps <= i_cfg_data[9:0];
                fft_pkg::REG_STEP_SIZE: r_step_size <= i_cfg_data[11:0];
                fft_pkg::REG_WIDTH:     r_width     <= i_cfg_data[8:0];
                fft_pkg::REG_HEIGHT:    r_height    <= i_cfg_data[8:0];
                fft_pkg::REG_THRESHOLD: r_thr       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic w_acc;
    assign o_in_stall = (r_state != fft_pkg::ST_IDLE) || r_ovalid;
    assign w_acc = i_in_valid && !o_in_stall;

    // neighbor addressing for read k (bit0 = +col, bit1 = +row)
    logic [15:0] w_cx0, w_cy0, w_cx, w_cy;
    logic [CB-1:0] w_col;
    logic [RB-1:0] w_row;
    always_comb begin
        w_cx0 = {8'd0, r_px[15:FB]} + {15'd0, r_k[0]};
        w_cy0 = {8'd0, r_py[15:FB]} + {15'd0, r_k[1]};
        w_cx  = (w_cx0 > {7'd0, r_wu} - 16'd1) ? {7'd0, r_wu} - 16'd1 : w_cx0;
        w_cy  = (w_cy0 > {7'd0, r_hu} - 16'd1) ? {7'd0, r_hu} - 16'd1 : w_cy0;
        w_col = w_cx[CB-1:0];
        w_row = w_cy[RB-1:0];
    end

    always_comb begin
        w_req = '0;
        w_req.wr_en   = w_acc && !i_req_type;
        w_req.wr_addr = {i_entry_row[RB-1:0], i_entry_col[CB-1:0]};
        w_req.wr_x    = i_entry_flow_x;
        w_req.wr_y    = i_entry_flow_y;
        w_req.rd_en   = (r_state == fft_pkg::ST_ADDR);
        w_req.rd_addr = {w_row, w_col};
    end

    fft_flow_mem u_mem (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rd_x(w_rd_x),
        .o_rd_y(w_rd_y)
    );

    // weight of neighbor k, Q1.16 (max 65536), registered in ST_READ for use in ST_ACC
    logic [8:0]  w_dx, w_dy, w_wx, w_wy;
    logic [17:0] w_wt;
    logic signed [35:0] w_px, w_py;
    always_comb begin
        w_dx = {1'b0, r_px[FB-1:0]};
        w_dy = {1'b0, r_py[FB-1:0]};
        w_wx = r_k[0] ? w_dx : 9'd256 - w_dx;
        w_wy = r_k[1] ? w_dy : 9'd256 - w_dy;
        w_wt = w_wx * w_wy;
        w_px = $signed({1'b0, r_wt}) * $signed(w_rd_x);
        w_py = $signed({1'b0, r_wt}) * $signed(w_rd_y);
    end

    // move step
    logic signed [19:0] w_ax, w_ay;
    logic signed [32:0] w_mx, w_my;
    logic signed [26:0] w_nx, w_ny;
    logic [15:0] w_xmax, w_ymax, w_cx_n, w_cy_n;
    logic        w_conv;
    always_comb begin
        w_ax = r_fx[19] ? -r_fx : r_fx;
        w_ay = r_fy[19] ? -r_fy : r_fy;
        w_conv = (w_ax < $signed({12'd0, r_thr})) && (w_ay < $signed({12'd0, r_thr}));
        w_mx = $signed({1'b0, r_step_size}) * r_fx;
        w_my = $signed({1'b0, r_step_size}) * r_fy;
        w_nx = $signed({11'd0, r_px}) + 27'(w_mx >>> fft_pkg::StepFrac);
        w_ny = $signed({11'd0, r_py}) + 27'(w_my >>> fft_pkg::StepFrac);
        w_xmax = {r_wu[7:0] - 8'd1, 8'd0};
        w_ymax = {r_hu[7:0] - 8'd1, 8'd0};
        w_cx_n = w_nx[26] ? 16'd0 :
                 (w_nx > $signed({11'd0, w_xmax})) ? w_xmax : w_nx[15:0];
        w_cy_n = w_ny[26] ? 16'd0 :
                 (w_ny > $signed({11'd0, w_ymax})) ? w_ymax : w_ny[15:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fft_pkg::ST_IDLE:
                if (w_acc && i_req_type) n_state = fft_pkg::ST_SUM;
            fft_pkg::ST_ADDR: n_state = fft_pkg::ST_READ;
            fft_pkg::ST_READ: n_state = fft_pkg::ST_ACC;
            fft_pkg::ST_ACC:
                n_state = (r_k == 2'd3) ? fft_pkg::ST_MOVE : fft_pkg::ST_ADDR;
            fft_pkg::ST_MOVE: n_state = fft_pkg::ST_SUM;
            fft_pkg::ST_SUM:
                n_state = (r_cnt == r_num_steps) ? fft_pkg::ST_OUT : fft_pkg::ST_ADDR;
            fft_pkg::ST_OUT: if (!r_ovalid) n_state = fft_pkg::ST_IDLE;
            default: n_state = fft_pkg::ST_IDLE;
        endcase
    end

    // ST_MOVE: fx/fy registered at the last accumulate; decide converge, else move.
    // ST_SUM: step bookkeeping (entry check for another step).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fft_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fft_pkg::ST_MOVE && w_conv) r_state <= fft_pkg::ST_OUT;
            if (o_out_valid && !i_out_stall) r_ovalid <= 1'b0;
            if (r_state == fft_pkg::ST_OUT && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_state  <= fft_pkg::ST_IDLE;
            end
        end
    end

    logic signed [35:0] w_sx_n, w_sy_n;
    assign w_sx_n = r_sx + w_px;
    assign w_sy_n = r_sy + w_py;

    always_ff @(posedge i_clk) begin
        if (r_state == fft_pkg::ST_IDLE && w_acc) begin
            r_px  <= i_start_x;
            r_py  <= i_start_y;
            r_cnt <= '0;
            r_wu  <= (r_width == 9'd0) ? 9'd1 :
                     (r_width > 9'(fft_pkg::MaxWidth)) ? 9'(fft_pkg::MaxWidth) : r_width;
            r_hu  <= (r_height == 9'd0) ? 9'd1 :
                     (r_height > 9'(fft_pkg::MaxHeight)) ? 9'(fft_pkg::MaxHeight) : r_height;
        end
        if (r_state == fft_pkg::ST_SUM) begin
            r_k  <= 2'd0;
            r_sx <= '0;
            r_sy <= '0;
        end
        if (r_state == fft_pkg::ST_READ) begin
            r_wt <= w_wt;
        end
        if (r_state == fft_pkg::ST_ACC) begin
            r_k  <= r_k + 2'd1;
            r_sx <= w_sx_n;
            r_sy <= w_sy_n;
        end
        if (r_state == fft_pkg::ST_ACC && r_k == 2'd3) begin
            r_fx <= 20'(w_sx_n >>> (2*FB));
            r_fy <= 20'(w_sy_n >>> (2*FB));
        end
        if (r_state == fft_pkg::ST_MOVE && !w_conv) begin
            r_px  <= w_cx_n;
            r_py  <= w_cy_n;
            r_cnt <= r_cnt + 10'd1;
        end
        if (r_state == fft_pkg::ST_OUT && !r_ovalid) begin
            r_ox <= r_px;
            r_oy <= r_py;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_end_x = r_ox;
    assign o_end_y = r_oy;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fft_pkg::ST_ADDR) |-> o_in_stall) else $error("accept while busy");
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fft_pkg::ST_ADDR) |-> (r_cnt < r_num_steps)) else $error("step overrun");
    a_read_then_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fft_pkg::ST_ADDR) |=> (r_state == fft_pkg::ST_READ))
        else $error("read sequence");
endmodule

// ----- verif/flow_field_tracer_tb.sv -----
// Self-checking testbench for the flow field tracer: random loads and traces against a predictor.
`timescale 1ns / 100ps

module flow_field_tracer_tb;
    localparam int  CycleLimit = 3000000;
    localparam int  DrainWait  = 20;
    localparam int  Depth      = fft_pkg::MaxWidth * fft_pkg::MaxHeight;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } t_pos;

    // Scoreboard: predicts end positions of traces and checks returned ones.
    class trace_scoreboard;
        logic signed [15:0] fld_x [0:Depth-1];
        logic signed [15:0] fld_y [0:Depth-1];
        int unsigned steps_reg, step_reg, width_reg, height_reg, thr_reg;
        t_pos end_q[$];
        int   errors;

        function new();
            steps_reg  = 200;
            step_reg   = 256;
            width_reg  = 256;
            height_reg = 256;
            thr_reg    = 1;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                fft_pkg::REG_NUM_STEPS: steps_reg  = val[9:0];
                fft_pkg::REG_STEP_SIZE: step_reg   = val[11:0];
                fft_pkg::REG_WIDTH:     width_reg  = val[8:0];
                fft_pkg::REG_HEIGHT:    height_reg = val[8:0];
                fft_pkg::REG_THRESHOLD: thr_reg    = val[7:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function t_pos follow_flow(logic [15:0] sx, logic [15:0] sy);
            longint w, h, px, py, cx0, cy0, cx1, cy1, dx, dy;
            longint w00, w01, w10, w11, sumx, sumy, fx, fy;
            int a00, a01, a10, a11;
            t_pos r;
            w  = (width_reg == 0) ? 1 :
                 (width_reg > fft_pkg::MaxWidth ? fft_pkg::MaxWidth : width_reg);
            h  = (height_reg == 0) ? 1 :
                 (height_reg > fft_pkg::MaxHeight ? fft_pkg::MaxHeight : height_reg);
            px = sx;
            py = sy;
            for (int i = 0; i < steps_reg; i++) begin
                cx0 = px >>> fft_pkg::FracBits;
                cy0 = py >>> fft_pkg::FracBits;
                dx  = px & 255;
                dy  = py & 255;
                cx1 = clip(cx0 + 1, 0, w - 1);
                cy1 = clip(cy0 + 1, 0, h - 1);
                cx0 = clip(cx0, 0, w - 1);
                cy0 = clip(cy0, 0, h - 1);
                w00 = (256 - dx) * (256 - dy);
                w01 = dx * (256 - dy);
                w10 = (256 - dx) * dy;
                w11 = dx * dy;
                a00 = int'(cy0 * fft_pkg::MaxWidth + cx0);
                a01 = int'(cy0 * fft_pkg::MaxWidth + cx1);
                a10 = int'(cy1 * fft_pkg::MaxWidth + cx0);
                a11 = int'(cy1 * fft_pkg::MaxWidth + cx1);
                sumx = w00 * longint'(fld_x[a00]) + w01 * longint'(fld_x[a01])
                     + w10 * longint'(fld_x[a10]) + w11 * longint'(fld_x[a11]);
                sumy = w00 * longint'(fld_y[a00]) + w01 * longint'(fld_y[a01])
                     + w10 * longint'(fld_y[a10]) + w11 * longint'(fld_y[a11]);
                fx = sumx >>> (2 * fft_pkg::FracBits);
                fy = sumy >>> (2 * fft_pkg::FracBits);
                if ((fx < 0 ? -fx : fx) < thr_reg && (fy < 0 ? -fy : fy) < thr_reg)
                    break;
                px = clip(px + ((longint'(step_reg) * fx) >>> fft_pkg::StepFrac),
                          0, (w - 1) << 8);
                py = clip(py + ((longint'(step_reg) * fy) >>> fft_pkg::StepFrac),
                          0, (h - 1) << 8);
            end
            r.x = px[15:0];
            r.y = py[15:0];
            return r;
        endfunction

        function void note_item(logic req, logic [7:0] col, logic [7:0] row,
                                logic [15:0] fx, logic [15:0] fy,
                                logic [15:0] sx, logic [15:0] sy);
            if (!req) begin
                fld_x[row * fft_pkg::MaxWidth + col] = fx;
                fld_y[row * fft_pkg::MaxWidth + col] = fy;
            end else begin
                end_q.push_back(follow_flow(sx, sy));
            end
        endfunction

        function void check_result(logic [15:0] ex, logic [15:0] ey);
            t_pos e;
            if (end_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result x=%h y=%h", ex, ey);
                return;
            end
            e = end_q.pop_front();
            if (e.x !== ex || e.y !== ey) begin
                errors++;
                if (errors <= 10)
                    $display("end position mismatch: expected x=%h y=%h, got x=%h y=%h",
                             e.x, e.y, ex, ey);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [7:0]  i_entry_col;
    logic [7:0]  i_entry_row;
    logic signed [15:0] i_entry_flow_x;
    logic signed [15:0] i_entry_flow_y;
    logic [15:0] i_start_x;
    logic [15:0] i_start_y;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_end_x;
    logic [15:0] o_end_y;

    flow_field_tracer dut (.*);

    trace_scoreboard sb = new();
    t_idle  idle_mode = IDLE_NONE;
    bit     loaded [0:Depth-1];
    int     cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("flow_field_tracer regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: i_out_stall = ($urandom_range(99) < 61);
            IDLE_BOTH: i_out_stall = ($urandom_range(99) < 8);
            default:   i_out_stall = 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_end_x, o_end_y);
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_item(logic req, logic [7:0] col, logic [7:0] row,
                             logic [15:0] fx, logic [15:0] fy,
                             logic [15:0] sx, logic [15:0] sy);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 8 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_req_type     = req;
        i_entry_col    = col;
        i_entry_row    = row;
        i_entry_flow_x = fx;
        i_entry_flow_y = fy;
        i_start_x      = sx;
        i_start_y      = sy;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.note_item(req, col, row, fx, fy, sx, sy);
        if (!req)
            loaded[row * fft_pkg::MaxWidth + col] = 1'b1;
    endtask

    function automatic logic [15:0] rand_flow();
        case ($urandom_range(3))
            0: return 16'(int'($urandom_range(8)) - 4);
            1: case ($urandom_range(3))
                   0: return 16'h8000;
                   1: return 16'h7fff;
                   2: return 16'h0000;
                   default: return 16'hffff;
               endcase
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_entry(int col, int row);
        send_item(1'b0, 8'(col), 8'(row), rand_flow(), rand_flow(), 16'($urandom), 16'($urandom));
    endtask

    task automatic trace_from(logic [15:0] sx, logic [15:0] sy);
        send_item(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), sx, sy);
    endtask

    // Lets the block drain, then applies one register set and covers the used area.
    task automatic start_phase(int steps, int step, int wr, int hr, int thr, t_idle mode);
        int w, h;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.end_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        idle_mode = mode;
        write_reg(fft_pkg::REG_NUM_STEPS, 16'(steps));
        write_reg(fft_pkg::REG_STEP_SIZE, 16'(step));
        write_reg(fft_pkg::REG_WIDTH,     16'(wr));
        write_reg(fft_pkg::REG_HEIGHT,    16'(hr));
        write_reg(fft_pkg::REG_THRESHOLD, 16'(thr));
        w = (wr == 0) ? 1 : (wr > fft_pkg::MaxWidth ? fft_pkg::MaxWidth : wr);
        h = (hr == 0) ? 1 : (hr > fft_pkg::MaxHeight ? fft_pkg::MaxHeight : hr);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (!loaded[r * fft_pkg::MaxWidth + c])
                    load_entry(c, r);
    endtask

    task automatic random_items(int n, int w, int h);
        logic [15:0] sx, sy;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 40) begin
                load_entry($urandom_range(255), $urandom_range(255));
            end else begin
                case ($urandom_range(7))
                    0: begin sx = 16'($urandom_range(1) * 16'hffff);
                             sy = 16'($urandom_range(1) * 16'hffff); end
                    1: begin sx = 16'($urandom); sy = 16'($urandom); end
                    default: begin
                        sx = 16'($urandom_range(w * 256 + 255));
                        sy = 16'($urandom_range(h * 256 + 255));
                    end
                endcase
                trace_from(sx, sy);
            end
        end
    endtask

    initial begin
        int w, h;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = fft_pkg::REG_NUM_STEPS;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_req_type     = 1'b0;
        i_entry_col    = '0;
        i_entry_row    = '0;
        i_entry_flow_x = '0;
        i_entry_flow_y = '0;
        i_start_x      = '0;
        i_start_y      = '0;
        i_out_stall    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero steps and zero sizes: start comes back as given
        start_phase(0, 0, 0, 0, 0, IDLE_NONE);
        trace_from(16'h0000, 16'h0000);
        trace_from(16'hffff, 16'hffff);
        trace_from(16'h0180, 16'h7f40);

        start_phase(6, 256, 4, 4, 1, IDLE_NONE);
        send_item(1'b0, 8'd0, 8'd0, 16'h7fff, 16'h8000, 16'h0, 16'h0);
        send_item(1'b0, 8'd255, 8'd255, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
        send_item(1'b0, 8'd1, 8'd1, 16'h0000, 16'h0000, 16'h0, 16'h0);
        send_item(1'b0, 8'd3, 8'd3, 16'h0080, 16'hff80, 16'h0, 16'h0);
        trace_from(16'h0000, 16'h0000);
        trace_from(16'hffff, 16'hffff);
        trace_from(16'h0180, 16'h0240);
        trace_from(16'h0300, 16'h0000);
        // all-zero neighborhood converges at once
        send_item(1'b0, 8'd2, 8'd2, 16'h0000, 16'h0000, 16'h0, 16'h0);
        send_item(1'b0, 8'd2, 8'd1, 16'h0000, 16'h0000, 16'h0, 16'h0);
        send_item(1'b0, 8'd1, 8'd2, 16'h0000, 16'h0000, 16'h0, 16'h0);
        trace_from(16'h0180, 16'h0180);

        start_phase(20, 4095, 8, 6, 255, IDLE_SEND);
        random_items(20, 8, 6);
        start_phase(1023, 128, 3, 3, 0, IDLE_RECV);
        random_items(8, 3, 3);
        start_phase(12, 300, 300, 1, 10, IDLE_BOTH);
        random_items(20, 256, 1);
        start_phase(12, 64, 1, 511, 2, IDLE_NONE);
        random_items(20, 1, 256);

        for (int p = 0; p < 10; p++) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            start_phase($urandom_range(0, 30), $urandom_range(4095), w, h,
                        $urandom_range(255), t_idle'(p % 4));
            random_items(8, w, h);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.end_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (sb.errors == 0 && sb.end_q.size() == 0)
            $display("flow_field_tracer regression: pass");
        else
            $display("flow_field_tracer regression: fail");
        $finish;
    end
endmodule

// ----- flow_field_tracer.f -----
sv/fft_pkg.sv
sv/fft_flow_mem.sv
sv/flow_field_tracer.sv
verif/flow_field_tracer_tb.sv
